>>> hdl/nvqp_pkg.sv
// Shared types, codes and constants for the NVMe I/O queue pair host block.
package nvqp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 8;
    localparam int unsigned PAGE_BYTES      = 4096;

    localparam logic [33:0] DOORBELL_BASE  = 34'h0_0000_1000;
    localparam logic [31:0] POLL_LIMIT_RST = 32'd50_000_000;
    localparam logic [3:0]  SSL_MIN        = 4'd9;
    localparam logic [3:0]  SSL_MAX        = 4'd12;
    localparam logic [7:0]  NVM_OP_WRITE   = 8'h01;
    localparam logic [7:0]  NVM_OP_READ    = 8'h02;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 176;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_POLL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_NOTHING  = 3'd0,
        KIND_OFFLINE  = 3'd1,
        KIND_TOO_MANY = 3'd2,
        KIND_BUSY     = 3'd3,
        KIND_SUBMIT   = 3'd4,
        KIND_OK       = 3'd5,
        KIND_ERROR    = 3'd6,
        KIND_TIMEOUT  = 3'd7
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ONLINE      = 3'd0,
        CFG_SECTOR_LOG2 = 3'd1,
        CFG_STRIDE_LOG2 = 3'd2,
        CFG_QUEUE_ID    = 3'd3,
        CFG_POLL_LIMIT  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic        online;
        logic [3:0]  sector_size_log2;
        logic [3:0]  doorbell_stride_log2;
        logic [15:0] queue_id;
        logic [31:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [63:0] start_block;
        logic [16:0] block_count;
        logic [31:0] completion_word;
    } item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [2:0]  slot_index;
        logic [31:0] command_dword0;
        logic [31:0] block_low_dword;
        logic [31:0] block_high_dword;
        logic [15:0] blocks_zero_based;
        logic [33:0] doorbell_offset;
        logic [2:0]  doorbell_value;
        logic [14:0] status_code;
    } res_t;

    // Doorbell offset: base + (2 * queue_id + which) * (4 << stride), kept to 34 bits.
    function automatic logic [33:0] doorbell_off(input cfg_t cfg, input logic which);
        logic [16:0] idx;
        logic [33:0] shifted;
        idx     = {cfg.queue_id, which};
        shifted = 34'(idx) << (5'(cfg.doorbell_stride_log2) + 5'd2);
        return DOORBELL_BASE + shifted;
    endfunction

endpackage

>>> hdl/nvqp_cfg_regs.sv
// Configuration registers of the queue pair host, written through a plain write port.
module nvqp_cfg_regs
    import nvqp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ONLINE:      cfg_next.online               = cfg_data[0];
                CFG_SECTOR_LOG2: cfg_next.sector_size_log2     = cfg_data[3:0];
                CFG_STRIDE_LOG2: cfg_next.doorbell_stride_log2 = cfg_data[3:0];
                CFG_QUEUE_ID:    cfg_next.queue_id             = cfg_data[15:0];
                CFG_POLL_LIMIT:  cfg_next.poll_limit           = cfg_data[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.online               <= 1'b0;
            cfg_reg.sector_size_log2     <= SSL_MIN;
            cfg_reg.doorbell_stride_log2 <= 4'd0;
            cfg_reg.queue_id             <= 16'd1;
            cfg_reg.poll_limit           <= POLL_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/nvqp_engine.sv
// Queue pair state and the combinational decision logic for one request or poll.
module nvqp_engine
    import nvqp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  item_valid,
    input  logic  adv,
    input  cfg_t  cfg,
    output res_t  res,
    output logic  res_valid,
    output logic  awaiting
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic             phase_reg, phase_next;
    logic [15:0]      cid_reg, cid_next;
    logic             await_reg, await_next;
    logic [31:0]      poll_cnt_reg, poll_cnt_next;

    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W+2:0] tail_ext, tail_inc_ext, head_ext, head_inc_ext;
    logic [3:0]       ssl;
    logic [16:0]      max_blocks;
    logic             emit;

    assign tail_inc     = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign head_inc     = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    // Slot fields are three bits wide whatever the queue depth.
    assign tail_ext     = {3'b000, tail_reg};
    assign tail_inc_ext = {3'b000, tail_inc};
    assign head_ext     = {3'b000, head_reg};
    assign head_inc_ext = {3'b000, head_inc};

    assign ssl = (cfg.sector_size_log2 >= SSL_MIN && cfg.sector_size_log2 <= SSL_MAX) ?
                 cfg.sector_size_log2 : SSL_MIN;
    assign max_blocks = 17'(PAGE_BYTES >> ssl);

    always_comb
    begin
        res           = res_t'('0);
        emit          = 1'b0;
        tail_next     = tail_reg;
        head_next     = head_reg;
        phase_next    = phase_reg;
        cid_next      = cid_reg;
        await_next    = await_reg;
        poll_cnt_next = poll_cnt_reg;

        unique case (item.opcode)
            OP_READ, OP_WRITE:
            begin
                emit = 1'b1;
                if (item.block_count == 17'd0)
                begin
                    res.result_kind = KIND_NOTHING;
                end
                else if (!cfg.online)
                begin
                    res.result_kind = KIND_OFFLINE;
                end
                else if (item.block_count > max_blocks)
                begin
                    res.result_kind = KIND_TOO_MANY;
                end
                else if (await_reg)
                begin
                    res.result_kind = KIND_BUSY;
                end
                else
                begin
                    res.result_kind       = KIND_SUBMIT;
                    res.slot_index        = tail_ext[2:0];
                    res.command_dword0    = {cid_reg, 8'h00,
                                             (item.opcode == OP_WRITE) ? NVM_OP_WRITE
                                                                       : NVM_OP_READ};
                    res.block_low_dword   = item.start_block[31:0];
                    res.block_high_dword  = item.start_block[63:32];
                    res.blocks_zero_based = 16'(item.block_count - 17'd1);
                    res.doorbell_offset   = doorbell_off(cfg, 1'b0);
                    res.doorbell_value    = tail_inc_ext[2:0];
                    tail_next             = tail_inc;
                    cid_next              = cid_reg + 16'd1;
                    await_next            = 1'b1;
                    poll_cnt_next         = '0;
                end
            end
            OP_POLL:
            begin
                if (!await_reg)
                begin
                    emit            = 1'b1;
                    res.result_kind = KIND_NOTHING;
                end
                else if (item.completion_word[16] != phase_reg)
                begin
                    // Phase tag not yet flipped by the controller: count toward timeout.
                    if ({1'b0, poll_cnt_reg} + 33'd1 >= {1'b0, cfg.poll_limit})
                    begin
                        emit            = 1'b1;
                        res.result_kind = KIND_TIMEOUT;
                        res.slot_index  = head_ext[2:0];
                        await_next      = 1'b0;
                        poll_cnt_next   = '0;
                    end
                    else
                    begin
                        poll_cnt_next = poll_cnt_reg + 32'd1;
                    end
                end
                else
                begin
                    emit                = 1'b1;
                    res.result_kind     = (item.completion_word[31:17] != 15'd0) ?
                                          KIND_ERROR : KIND_OK;
                    res.slot_index      = head_ext[2:0];
                    res.doorbell_offset = doorbell_off(cfg, 1'b1);
                    res.doorbell_value  = head_inc_ext[2:0];
                    res.status_code     = item.completion_word[31:17];
                    head_next           = head_inc;
                    if (head_inc == '0)
                    begin
                        phase_next = ~phase_reg;
                    end
                    await_next    = 1'b0;
                    poll_cnt_next = '0;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= '0;
            head_reg     <= '0;
            phase_reg    <= 1'b1;
            cid_reg      <= 16'd1;
            await_reg    <= 1'b0;
            poll_cnt_reg <= '0;
        end
        else if (adv)
        begin
            tail_reg     <= tail_next;
            head_reg     <= head_next;
            phase_reg    <= phase_next;
            cid_reg      <= cid_next;
            await_reg    <= await_next;
            poll_cnt_reg <= poll_cnt_next;
        end
    end

    assign res_valid = item_valid && emit;
    assign awaiting  = await_reg;

endmodule

>>> hdl/nvqp_out_reg.sv
// Result register that holds one finished result until the master side takes it.
module nvqp_out_reg
    import nvqp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  res_t                   res,
    output logic                   can_take,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic valid_reg, valid_next;
    res_t res_reg;

    assign can_take   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0,
                       res_reg.status_code,
                       res_reg.doorbell_value,
                       res_reg.doorbell_offset,
                       res_reg.blocks_zero_based,
                       res_reg.block_high_dword,
                       res_reg.block_low_dword,
                       res_reg.command_dword0,
                       res_reg.slot_index,
                       res_reg.result_kind};

endmodule

>>> hdl/nvme_io_queue_pair_host_top.sv
// Top level of the NVMe I/O queue pair host: input register, engine and result register.
//
// Takes one read request, write request or completion poll per clock cycle while the
// master side does not stall. An accepted transaction is held in the input register and
// its result is then loaded into the result register, which offers it on the master
// side. The rate rests on the registered update of the queue pointers, command
// id, phase and poll counter, which every item reads and writes. When the master side
// stalls with a result waiting, the held item stays in the input register and the slave
// side stops accepting. A poll whose phase tag does not match gives no result until the
// poll limit is reached. Configuration writes take effect on the next cycle and are meant
// to happen only while no item is in flight.
module nvme_io_queue_pair_host_top
    import nvqp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: opcode[1:0], start_block[65:2], block_count[82:66],
    // completion_word[114:83], zero fill above
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: result_kind[2:0], slot_index[5:3], command_dword0[37:6],
    // block_low_dword[69:38], block_high_dword[101:70], blocks_zero_based[117:102],
    // doorbell_offset[151:118], doorbell_value[154:152], status_code[169:155], zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    item_t item_reg;
    item_t item_in;
    logic  in_valid_reg, in_valid_next;
    logic  adv;
    logic  can_take;
    res_t  res;
    logic  res_valid;
    logic  awaiting;

    assign item_in.opcode          = op_t'(s_tdata[1:0]);
    assign item_in.start_block     = s_tdata[65:2];
    assign item_in.block_count     = s_tdata[82:66];
    assign item_in.completion_word = s_tdata[114:83];

    // The held item moves on whenever the result register can take its result.
    assign adv           = in_valid_reg && can_take;
    assign s_tready      = !in_valid_reg || adv;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    nvqp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nvqp_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_reg),
        .item_valid (in_valid_reg),
        .adv        (adv),
        .cfg        (cfg),
        .res        (res),
        .res_valid  (res_valid),
        .awaiting   (awaiting)
    );

    nvqp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv && res_valid),
        .res      (res),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A submitted command leaves the pair waiting for its completion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid && res.result_kind == KIND_SUBMIT) |=> awaiting)
        else $error("submission did not mark a command in flight");

    // A completion or a timeout ends the wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid && (res.result_kind == KIND_OK || res.result_kind == KIND_ERROR ||
                              res.result_kind == KIND_TIMEOUT)) |=> !awaiting)
        else $error("completion or timeout left a command in flight");

    // Rejections and no-op results leave the wait state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid && (res.result_kind == KIND_NOTHING ||
                              res.result_kind == KIND_OFFLINE ||
                              res.result_kind == KIND_TOO_MANY ||
                              res.result_kind == KIND_BUSY)) |=> (awaiting == $past(awaiting)))
        else $error("rejected transaction changed the wait state");

    // Nothing is taken into the engine's result path while the result register is full and not being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !adv)
        else $error("item advanced while the result register was stalled");

endmodule
